[hw/rtl/olbs_pkg.sv]
package olbs_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_INV_RELAX    = 2'd0;
   localparam logic [1:0] CSR_TIME_STEP    = 2'd1;
   localparam logic [1:0] CSR_STRESS_SCALE = 2'd2;

   localparam logic [23:0] INV_RELAX_RESET    = 24'd65536;
   localparam logic [31:0] TIME_STEP_RESET    = 32'd4294967;
   localparam logic [23:0] STRESS_SCALE_RESET = 24'd32768;

   // 1.0 in Q16.16, one bit wider than a tensor value.
   localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

   // Register stages from the input register to the output register.
   localparam int NUM_STAGES = 10;

   typedef logic signed [31:0] q16_type;

   typedef struct packed {
      q16_type value;
      logic    clip;
   } sat_type;

   // Clips a wide signed value to the 32-bit range and reports the clip.
   function automatic sat_type sat_q16(input logic signed [53:0] v);
      sat_type r;
      if ((v[53:31] == '0) || (v[53:31] == '1)) begin
         r.value = v[31:0];
         r.clip  = 1'b0;
      end else begin
         r.value = v[53] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

[hw/rtl/oldroyd_b_local_step_top.sv]
// One forward-Euler step of the local Oldroyd-B conformation update per grid point,
// followed by the polymer stress beta*(S - I) of the updated tensor, all in signed
// Q16.16 with saturation. A transaction is accepted every clock unless a valid
// output is stalled, and passes the ten-stage pipeline (inputs, products, rounding,
// sums, the split dt multiply, the update add, the stress multiply and the output
// register). A stalled output holds the whole pipeline. The user must write the
// registers only while no transaction is in flight; the block does not enforce it.
module oldroyd_b_local_step_top
   import olbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic        [1:0]   csr_index,
   input  logic        [31:0]  csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_conf_xx,
   input  logic signed [31:0]  req_conf_xy,
   input  logic signed [31:0]  req_conf_yy,
   input  logic signed [31:0]  req_grad_xx,
   input  logic signed [31:0]  req_grad_xy,
   input  logic signed [31:0]  req_grad_yx,
   input  logic signed [31:0]  req_grad_yy,
   input  logic                req_last_point,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_new_xx,
   output logic signed [31:0]  rsp_new_xy,
   output logic signed [31:0]  rsp_new_yy,
   output logic signed [31:0]  rsp_stress_xx,
   output logic signed [31:0]  rsp_stress_xy,
   output logic signed [31:0]  rsp_stress_yy,
   output logic                rsp_saturated,
   output logic                rsp_last_out
);

   function automatic logic signed [48:0] rnd15(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd16384;
      return t[63:15];
   endfunction

   function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd32768;
      return t[63:16];
   endfunction

   function automatic logic signed [40:0] rnd16t(input logic signed [56:0] p);
      logic signed [56:0] t;
      t = p + 57'sd32768;
      return t[56:16];
   endfunction

   logic [23:0] inv_relax_ff;
   logic [31:0] time_step_ff;
   logic [23:0] stress_scale_ff;

   logic                  en;
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] last_ff, last_in;

   // Stage 1: input registers.
   q16_type s_xx_ff, s_xy_ff, s_yy_ff;
   q16_type k_xx_ff, k_xy_ff, k_yx_ff, k_yy_ff;

   // Stage 2: products.
   logic signed [63:0] p_xx_kxx_ff, p_xy_kxy_ff, p_xx_kyx_ff, p_xy_kxx_ff;
   logic signed [63:0] p_xy_kyy_ff, p_yy_kxy_ff, p_yy_kyy_ff, p_xy_kyx_ff;
   logic signed [56:0] p_xx_t_ff, p_xy_t_ff, p_yy_t_ff;
   q16_type            s2_ff [3];

   // Stage 3: rounded terms.
   logic signed [48:0] r_xx_kxx_ff, r_xy_kxy_ff, r_yy_kyy_ff, r_xy_kyx_ff;
   logic signed [47:0] r_xx_kyx_ff, r_xy_kxx_ff, r_xy_kyy_ff, r_yy_kxy_ff;
   logic signed [40:0] r_xx_t_ff, r_xy_t_ff, r_yy_t_ff;
   q16_type            s3_ff [3];

   // Stage 4: derivatives.
   logic signed [51:0] d_ff [3];
   logic signed [51:0] d_in [3];
   logic signed [51:0] t_ext;
   q16_type            s4_ff [3];

   // Stages 5 to 8: dt lanes.
   sat_type lane_res [3];

   // Stage 9: stress products.
   logic signed [57:0] prod_ff [3];
   logic signed [57:0] prod_in [3];
   q16_type            n9_ff [3];
   logic               clip9_ff;

   // Stage 10: output register.
   q16_type n10_ff [3];
   q16_type str_ff [3];
   sat_type str_in [3];
   logic    sat_ff, sat_in;
   logic signed [57:0] rnd_sum [3];

   assign en        = !(valid_ff[NUM_STAGES-1] && rsp_stall);
   assign req_stall = !en;
   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign last_in   = {last_ff[NUM_STAGES-2:0], req_last_point};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_relax_ff    <= INV_RELAX_RESET;
         time_step_ff    <= TIME_STEP_RESET;
         stress_scale_ff <= STRESS_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_RELAX:    inv_relax_ff    <= csr_wdata[23:0];
            CSR_TIME_STEP:    time_step_ff    <= csr_wdata;
            CSR_STRESS_SCALE: stress_scale_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign t_ext = $signed({28'd0, inv_relax_ff});
   assign d_in[0] = 52'(r_xx_kxx_ff) - 52'(r_xx_t_ff) + 52'(r_xy_kxy_ff) + t_ext;
   assign d_in[1] = 52'(r_xx_kyx_ff) + 52'(r_xy_kxx_ff) + 52'(r_xy_kyy_ff)
                  - 52'(r_xy_t_ff) + 52'(r_yy_kxy_ff);
   assign d_in[2] = 52'(r_yy_kyy_ff) - 52'(r_yy_t_ff) + 52'(r_xy_kyx_ff) + t_ext;

   // The off-diagonal stress has no identity term.
   assign prod_in[0] = $signed({1'b0, stress_scale_ff}) * (33'(lane_res[0].value) - ONE_Q16);
   assign prod_in[1] = $signed({1'b0, stress_scale_ff}) * 33'(lane_res[1].value);
   assign prod_in[2] = $signed({1'b0, stress_scale_ff}) * (33'(lane_res[2].value) - ONE_Q16);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd_sum[i] = prod_ff[i] + 58'sd32768;
         str_in[i]  = sat_q16(54'($signed(rnd_sum[i][57:16])));
      end
      sat_in = clip9_ff || str_in[0].clip || str_in[1].clip || str_in[2].clip;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= last_in;

         s_xx_ff <= req_conf_xx;
         s_xy_ff <= req_conf_xy;
         s_yy_ff <= req_conf_yy;
         k_xx_ff <= req_grad_xx;
         k_xy_ff <= req_grad_xy;
         k_yx_ff <= req_grad_yx;
         k_yy_ff <= req_grad_yy;

         p_xx_kxx_ff <= s_xx_ff * k_xx_ff;
         p_xy_kxy_ff <= s_xy_ff * k_xy_ff;
         p_xx_kyx_ff <= s_xx_ff * k_yx_ff;
         p_xy_kxx_ff <= s_xy_ff * k_xx_ff;
         p_xy_kyy_ff <= s_xy_ff * k_yy_ff;
         p_yy_kxy_ff <= s_yy_ff * k_xy_ff;
         p_yy_kyy_ff <= s_yy_ff * k_yy_ff;
         p_xy_kyx_ff <= s_xy_ff * k_yx_ff;
         p_xx_t_ff   <= s_xx_ff * $signed({1'b0, inv_relax_ff});
         p_xy_t_ff   <= s_xy_ff * $signed({1'b0, inv_relax_ff});
         p_yy_t_ff   <= s_yy_ff * $signed({1'b0, inv_relax_ff});
         s2_ff[0]    <= s_xx_ff;
         s2_ff[1]    <= s_xy_ff;
         s2_ff[2]    <= s_yy_ff;

         // Doubled diagonal terms round at one bit less of shift.
         r_xx_kxx_ff <= rnd15(p_xx_kxx_ff);
         r_xy_kxy_ff <= rnd15(p_xy_kxy_ff);
         r_yy_kyy_ff <= rnd15(p_yy_kyy_ff);
         r_xy_kyx_ff <= rnd15(p_xy_kyx_ff);
         r_xx_kyx_ff <= rnd16(p_xx_kyx_ff);
         r_xy_kxx_ff <= rnd16(p_xy_kxx_ff);
         r_xy_kyy_ff <= rnd16(p_xy_kyy_ff);
         r_yy_kxy_ff <= rnd16(p_yy_kxy_ff);
         r_xx_t_ff   <= rnd16t(p_xx_t_ff);
         r_xy_t_ff   <= rnd16t(p_xy_t_ff);
         r_yy_t_ff   <= rnd16t(p_yy_t_ff);
         s3_ff       <= s2_ff;

         d_ff  <= d_in;
         s4_ff <= s3_ff;

         prod_ff  <= prod_in;
         n9_ff[0] <= lane_res[0].value;
         n9_ff[1] <= lane_res[1].value;
         n9_ff[2] <= lane_res[2].value;
         clip9_ff <= lane_res[0].clip || lane_res[1].clip || lane_res[2].clip;

         n10_ff    <= n9_ff;
         str_ff[0] <= str_in[0].value;
         str_ff[1] <= str_in[1].value;
         str_ff[2] <= str_in[2].value;
         sat_ff    <= sat_in;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      olbs_dt_lane u_lane (
         .clock  (clock),
         .en     (en),
         .deriv  (d_ff[g]),
         .conf   (s4_ff[g]),
         .dt     (time_step_ff),
         .result (lane_res[g])
      );
   end

   assign rsp_valid     = valid_ff[NUM_STAGES-1];
   assign rsp_new_xx    = n10_ff[0];
   assign rsp_new_xy    = n10_ff[1];
   assign rsp_new_yy    = n10_ff[2];
   assign rsp_stress_xx = str_ff[0];
   assign rsp_stress_xy = str_ff[1];
   assign rsp_stress_yy = str_ff[2];
   assign rsp_saturated = sat_ff;
   assign rsp_last_out  = last_ff[NUM_STAGES-1];

endmodule

[hw/rtl/olbs_dt_lane.sv]
module olbs_dt_lane
   import olbs_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic signed [51:0]  deriv,
   input  q16_type             conf,
   input  logic        [31:0]  dt,
   output sat_type             result
);

   // Four stages: magnitude, two partial products, rounding, add and clip.
   logic        [50:0] mag_ff, mag_in;
   logic               neg1_ff, neg2_ff, neg3_ff;
   q16_type            conf1_ff, conf2_ff, conf3_ff;
   logic        [56:0] lo_ff, lo_in;
   logic        [57:0] hi_ff, hi_in;
   logic        [83:0] total;
   logic        [51:0] quot_ff, quot_in;
   logic signed [53:0] sum;
   sat_type            result_ff, result_in;

   assign mag_in  = deriv[51] ? 51'(-deriv) : 51'(deriv);
   assign lo_in   = 57'(mag_ff[24:0]) * 57'(dt);
   assign hi_in   = 58'(mag_ff[50:25]) * 58'(dt);
   // The increment is rounded on its magnitude, halves away from zero.
   assign total   = {1'b0, hi_ff, 25'd0} + 84'(lo_ff) + 84'h8000_0000;
   assign quot_in = total[83:32];
   assign sum     = neg3_ff ? (54'(conf3_ff) - $signed({2'b00, quot_ff}))
                            : (54'(conf3_ff) + $signed({2'b00, quot_ff}));
   assign result_in = sat_q16(sum);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= mag_in;
         neg1_ff   <= deriv[51];
         conf1_ff  <= conf;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         neg2_ff   <= neg1_ff;
         conf2_ff  <= conf1_ff;
         quot_ff   <= quot_in;
         neg3_ff   <= neg2_ff;
         conf3_ff  <= conf2_ff;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[tb/sv/local_step_check.sv]
`timescale 1ns / 100ps

module local_step_check
   import olbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_conf_xx,
   input  logic signed [31:0] req_conf_xy,
   input  logic signed [31:0] req_conf_yy,
   input  logic signed [31:0] req_grad_xx,
   input  logic signed [31:0] req_grad_xy,
   input  logic signed [31:0] req_grad_yx,
   input  logic signed [31:0] req_grad_yy,
   input  logic               req_last_point,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_new_xx,
   input  logic signed [31:0] rsp_new_xy,
   input  logic signed [31:0] rsp_new_yy,
   input  logic signed [31:0] rsp_stress_xx,
   input  logic signed [31:0] rsp_stress_xy,
   input  logic signed [31:0] rsp_stress_yy,
   input  logic               rsp_saturated,
   input  logic               rsp_last_out,
   output int                 mismatch_count,
   output int                 points_in_flight
);

   typedef struct packed {
      logic signed [31:0] conf_xx;
      logic signed [31:0] conf_xy;
      logic signed [31:0] conf_yy;
      logic signed [31:0] grad_xx;
      logic signed [31:0] grad_xy;
      logic signed [31:0] grad_yx;
      logic signed [31:0] grad_yy;
      logic               last_point;
   } grid_point_type;

   typedef struct packed {
      logic signed [31:0] new_xx;
      logic signed [31:0] new_xy;
      logic signed [31:0] new_yy;
      logic signed [31:0] stress_xx;
      logic signed [31:0] stress_xy;
      logic signed [31:0] stress_yy;
      logic               saturated;
      logic               last_out;
   } point_update_type;

   localparam longint Q16_MAX = 64'sd2147483647;
   localparam longint Q16_MIN = -64'sd2147483648;

   logic [23:0] inv_relax;
   logic [31:0] time_step;
   logic [23:0] stress_scale;

   point_update_type expected_points[$];

   // Rounds p / 2^sh to nearest, ties toward plus infinity.
   function automatic longint half_up(input longint p, input int sh);
      return (p + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   // Multiplies by the Q0.32 time step; the magnitude is rounded half up and the
   // sign is put back afterwards, so the rounding is symmetric about zero.
   function automatic longint scale_by_dt(input longint d, input logic [31:0] dt);
      logic [63:0] mag;
      logic [95:0] prod;
      longint      q;
      mag  = (d < 0) ? -d : d;
      prod = {32'b0, mag} * {64'b0, dt};
      prod = prod + 96'h8000_0000;
      q    = prod[95:32];
      return (d < 0) ? -q : q;
   endfunction

   // Returns the clip flag above the clipped 32-bit value.
   function automatic logic [32:0] clamp_q16(input longint v);
      if (v > Q16_MAX) begin
         return {1'b1, 32'h7fff_ffff};
      end
      if (v < Q16_MIN) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic point_update_type advance_conformation(input grid_point_type p);
      longint           sxx, sxy, syy, kxx, kxy, kyx, kyy, relax, beta, one;
      longint           rate_xx, rate_xy, rate_yy;
      logic [32:0]      c;
      logic             clipped;
      point_update_type r;
      sxx   = $signed(p.conf_xx);
      sxy   = $signed(p.conf_xy);
      syy   = $signed(p.conf_yy);
      kxx   = $signed(p.grad_xx);
      kxy   = $signed(p.grad_xy);
      kyx   = $signed(p.grad_yx);
      kyy   = $signed(p.grad_yy);
      relax = longint'(inv_relax);
      beta  = longint'(stress_scale);
      one   = longint'(ONE_Q16);

      // The doubled products take one bit less of shift so they round as a whole.
      rate_xx = half_up(sxx * kxx, 15) - half_up(sxx * relax, 16)
              + half_up(sxy * kxy, 15) + relax;
      rate_xy = half_up(sxx * kyx, 16) + half_up(sxy * kxx, 16) + half_up(sxy * kyy, 16)
              - half_up(sxy * relax, 16) + half_up(syy * kxy, 16);
      rate_yy = half_up(syy * kyy, 15) - half_up(syy * relax, 16)
              + half_up(sxy * kyx, 15) + relax;

      c = clamp_q16(sxx + scale_by_dt(rate_xx, time_step));
      r.new_xx = c[31:0];
      clipped  = c[32];
      c = clamp_q16(sxy + scale_by_dt(rate_xy, time_step));
      r.new_xy = c[31:0];
      clipped |= c[32];
      c = clamp_q16(syy + scale_by_dt(rate_yy, time_step));
      r.new_yy = c[31:0];
      clipped |= c[32];

      // The stress is formed from the already clipped tensor.
      c = clamp_q16(half_up(beta * (longint'($signed(r.new_xx)) - one), 16));
      r.stress_xx = c[31:0];
      clipped |= c[32];
      c = clamp_q16(half_up(beta * longint'($signed(r.new_xy)), 16));
      r.stress_xy = c[31:0];
      clipped |= c[32];
      c = clamp_q16(half_up(beta * (longint'($signed(r.new_yy)) - one), 16));
      r.stress_yy = c[31:0];
      clipped |= c[32];

      r.saturated = clipped;
      r.last_out  = p.last_point;
      return r;
   endfunction

   function automatic string show_update(input point_update_type r);
      return $sformatf("new %h %h %h stress %h %h %h sat %b last %b",
                       r.new_xx, r.new_xy, r.new_yy, r.stress_xx, r.stress_xy,
                       r.stress_yy, r.saturated, r.last_out);
   endfunction

   always @(posedge clock) begin : watch
      grid_point_type   point;
      point_update_type seen, want;
      if (reset) begin
         inv_relax    <= INV_RELAX_RESET;
         time_step    <= TIME_STEP_RESET;
         stress_scale <= STRESS_SCALE_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_new_xx, rsp_new_xy, rsp_new_yy, rsp_stress_xx, rsp_stress_xy,
                    rsp_stress_yy, rsp_saturated, rsp_last_out};
            if (expected_points.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: result with no transaction pending: %s",
                           $time, show_update(seen));
               end
               mismatch_count++;
            end else begin
               want = expected_points.pop_front();
               if (seen !== want) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: mismatch, expected %s", $time, show_update(want));
                     $display("%0t:           actual   %s", $time, show_update(seen));
                  end
                  mismatch_count++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            point = {req_conf_xx, req_conf_xy, req_conf_yy, req_grad_xx, req_grad_xy,
                     req_grad_yx, req_grad_yy, req_last_point};
            expected_points.push_back(advance_conformation(point));
         end

         // Writes to an index past the last register are dropped.
         if (csr_we) begin
            case (csr_index)
               CSR_INV_RELAX:    inv_relax    <= csr_wdata[23:0];
               CSR_TIME_STEP:    time_step    <= csr_wdata;
               CSR_STRESS_SCALE: stress_scale <= csr_wdata[23:0];
               default: ;
            endcase
         end
      end
      points_in_flight <= expected_points.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import olbs_pkg::*;

   localparam int CLK_PERIOD = 20;
   localparam int PHASES = 8;
   localparam int POINTS_PER_PHASE = 250;

   localparam logic [1:0]  CSR_SPARE = 2'd3;
   localparam logic [31:0] Q_ZERO = 32'h0000_0000;
   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] Q_TWO  = 32'h0002_0000;
   localparam logic [31:0] Q_HALF = 32'h0000_8000;
   localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN  = 32'h8000_0000;
   localparam logic [31:0] Q_LSB_NEG = 32'hffff_ffff;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTS}
      stall_style_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic        [1:0]  csr_index = CSR_INV_RELAX;
   logic        [31:0] csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_conf_xx = '0;
   logic signed [31:0] req_conf_xy = '0;
   logic signed [31:0] req_conf_yy = '0;
   logic signed [31:0] req_grad_xx = '0;
   logic signed [31:0] req_grad_xy = '0;
   logic signed [31:0] req_grad_yx = '0;
   logic signed [31:0] req_grad_yy = '0;
   logic               req_last_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_new_xx;
   logic signed [31:0] rsp_new_xy;
   logic signed [31:0] rsp_new_yy;
   logic signed [31:0] rsp_stress_xx;
   logic signed [31:0] rsp_stress_xy;
   logic signed [31:0] rsp_stress_yy;
   logic               rsp_saturated;
   logic               rsp_last_out;
   int                 mismatch_count;
   int                 points_in_flight;

   stall_style_type stall_style = STALL_NONE;
   int              stall_left = 0;

   oldroyd_b_local_step_top dut (.*);

   local_step_check step_check (.*);

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * 400_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // The receiver switches at random between stall styles.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(8, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_left[2];
      endcase
   end

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_point(input logic [31:0] cxx, cxy, cyy, gxx, gxy, gyx, gyy,
                             input logic last);
      bit held;
      req_valid      <= 1'b1;
      req_conf_xx    <= cxx;
      req_conf_xy    <= cxy;
      req_conf_yy    <= cyy;
      req_grad_xx    <= gxx;
      req_grad_xy    <= gxy;
      req_grad_yx    <= gyx;
      req_grad_yy    <= gyy;
      req_last_point <= last;
      do begin
         @(negedge clock);
         held = req_stall;
         @(posedge clock);
      end while (held);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
   endtask

   task automatic program_regs(input logic [31:0] relax, dt, beta, input bit poke_spare);
      csr_we    <= 1'b1;
      csr_index <= CSR_INV_RELAX;
      csr_wdata <= relax;
      @(posedge clock);
      csr_index <= CSR_TIME_STEP;
      csr_wdata <= dt;
      @(posedge clock);
      csr_index <= CSR_STRESS_SCALE;
      csr_wdata <= beta;
      @(posedge clock);
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_directed();
      send_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);
      send_point(Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1);
      send_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
      send_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
      send_point(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0);
      send_point(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1);
      send_point(Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG,
                 Q_LSB_NEG, 1'b0);
      // Simple shear acting on a stretched tensor.
      send_point(Q_TWO, Q_HALF, Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 1'b1);
   endtask

   // Mostly physical magnitudes, with full-range and extreme values mixed in.
   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         3, 4:    return $urandom;
         5:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         6:       return Q_ONE + $urandom_range(0, 255) - 32'd128;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // One choice leaves the bits above the 24-bit registers random on purpose.
   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'h00ff_ffff;
         2:       return $urandom;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_dt();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hffff_ffff;
         2:       return $urandom;
         default: return $urandom_range(0, 32'h0100_0000);
      endcase
   endfunction

   initial begin
      int phase, sent, burst, gap, k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain();
      program_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      run_directed();
      drain();
      // A zero time step must pass the tensor through unchanged.
      program_regs(INV_RELAX_RESET, 32'h0, Q_ONE, 1'b0);
      run_directed();
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            program_regs(32'h0, pick_dt(), 32'h0, 1'b1);
         end else begin
            program_regs(pick_scale(), pick_dt(), pick_scale(), phase[0]);
         end
         sent = 0;
         while (sent < POINTS_PER_PHASE) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < POINTS_PER_PHASE; k++) begin
               send_point(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                          pick_q16(), pick_q16(), $urandom_range(0, 15) == 0);
               sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         drain();
      end

      repeat (2 * NUM_STAGES) @(posedge clock);
      if (mismatch_count == 0 && points_in_flight == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/olbs_pkg.sv
hw/rtl/olbs_dt_lane.sv
hw/rtl/oldroyd_b_local_step_top.sv
tb/sv/local_step_check.sv
tb/sv/testbench.sv
